// File: design/eip_pkg.sv
// Shared types and codes for the external interrupt pin controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package eip_pkg;

    // Geometry of the register file
    localparam int WORD_BITS       = 32;
    localparam int PIN_LIMIT       = 8;
    localparam int PRIO_BITS       = 4;
    localparam int SENSE_CODE_BITS = 4;

    // Defaults for top-level parameters
    localparam int PIN_COUNT_DEF  = 8;
    localparam int SENSE_BITS_DEF = 4;

    // Item operations
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Register selects
    localparam logic [2:0] REG_SENSE  = 3'd0;
    localparam logic [2:0] REG_PRIO   = 3'd1;
    localparam logic [2:0] REG_SOURCE = 3'd2;
    localparam logic [2:0] REG_MASK   = 3'd3;
    localparam logic [2:0] REG_CLEAR  = 3'd4;

    // Sense codes
    localparam logic [SENSE_CODE_BITS-1:0] SENSE_FALL = 4'h0;
    localparam logic [SENSE_CODE_BITS-1:0] SENSE_RISE = 4'h1;
    localparam logic [SENSE_CODE_BITS-1:0] SENSE_LOW  = 4'h2;
    localparam logic [SENSE_CODE_BITS-1:0] SENSE_HIGH = 4'h3;
    localparam logic [SENSE_CODE_BITS-1:0] SENSE_BOTH = 4'h4;

    // Per-lane control from the register stage
    typedef struct packed {
        logic tick;      // sample pins this item
        logic src_wr;    // SOURCE write this item
        logic src_keep;  // written bit for this pin's pending flag
        logic pend;      // current pending flag
        logic mask;      // mask flag after this item
        logic prio_nz;   // priority field after this item is nonzero
        logic prev;      // previous pin level
        logic cur;       // sampled pin level
    } lane_ctrl_t;

    // Per-lane findings
    typedef struct packed {
        logic pend_next;
        logic line;
    } lane_out_t;

    // One result word
    typedef struct packed {
        logic [WORD_BITS-1:0] read_data;
        logic [PIN_LIMIT-1:0] irq_lines;
        logic                 shared_irq;
    } eip_result_t;

endpackage

// File: design/eip_lane.sv
// One pin lane: sense match, pending update and request line.
// Depends on eip_pkg.
`timescale 1ns / 1ps

module eip_lane
    import eip_pkg::*;
#(
    parameter int SENSE_FIELD_BITS = SENSE_BITS_DEF
) (
    input  logic [SENSE_FIELD_BITS-1:0] sense_code,
    input  lane_ctrl_t                  ctrl,
    output lane_out_t                   result
);

    logic [SENSE_CODE_BITS-1:0] code;
    logic                       fire;

    assign code = SENSE_CODE_BITS'(sense_code);

    // Pin activity against the sense code; unknown codes never fire
    always_comb begin
        unique case (code)
            SENSE_FALL: fire = ctrl.prev & ~ctrl.cur;
            SENSE_RISE: fire = ~ctrl.prev & ctrl.cur;
            SENSE_LOW:  fire = ~ctrl.cur;
            SENSE_HIGH: fire = ctrl.cur;
            SENSE_BOTH: fire = ctrl.prev ^ ctrl.cur;
            default:    fire = 1'b0;
        endcase
    end

    // Pending flag: set on a matching tick, cleared by a SOURCE write of 0
    always_comb begin
        priority if (ctrl.tick) begin
            result.pend_next = ctrl.pend | fire;
        end else if (ctrl.src_wr) begin
            result.pend_next = ctrl.pend & ctrl.src_keep;
        end else begin
            result.pend_next = ctrl.pend;
        end
        result.line = result.pend_next & ~ctrl.mask & ctrl.prio_nz;
    end

endmodule

// File: design/eip_merge.sv
// Merge of the lane findings into pending byte, request lines and shared line.
// Depends on eip_pkg.
`timescale 1ns / 1ps

module eip_merge
    import eip_pkg::*;
#(
    parameter int PIN_COUNT = PIN_COUNT_DEF
) (
    input  lane_out_t [PIN_COUNT-1:0] lanes,
    output logic      [PIN_LIMIT-1:0] pend_next,
    output logic      [PIN_LIMIT-1:0] irq_lines,
    output logic                      shared_irq
);

    // Pending byte is pin 0 at the top; lines are pin 0 at the bottom
    always_comb begin
        pend_next = '0;
        irq_lines = '0;
        for (int k = 0; k < PIN_COUNT; k++) begin
            pend_next[PIN_LIMIT-1-k] = lanes[k].pend_next;
            irq_lines[k]             = lanes[k].line;
        end
        shared_irq = |irq_lines;
    end

endmodule

// File: design/eip_out_buf.sv
// Two-entry result buffer: output register plus skid register.
// Depends on eip_pkg.
`timescale 1ns / 1ps

module eip_out_buf
    import eip_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_accept,
    input  eip_result_t in_word,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output eip_result_t out_word,
    output logic        skid_valid
);

    logic        out_valid_reg;
    logic        skid_valid_reg;
    eip_result_t out_word_reg;
    eip_result_t skid_word_reg;
    logic        out_fire;

    assign out_fire   = out_valid_reg & out_ready;
    assign in_ready   = ~skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_word   = out_word_reg;
    assign skid_valid = skid_valid_reg;

    // Control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_fire) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (in_accept) begin
            if (out_valid_reg && !out_ready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (out_fire) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload words
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_fire) begin
                out_word_reg <= skid_word_reg;
            end
        end else if (in_accept) begin
            if (out_valid_reg && !out_ready) begin
                skid_word_reg <= in_word;
            end else begin
                out_word_reg <= in_word;
            end
        end
    end

endmodule

// File: design/external_irq_pin_controller_unit.sv
// Eight-pin external interrupt controller, top level.
// All pin lanes evaluate in the same cycle, and the result word is registered.
// Throughput: one item per cycle while the skid entry of the buffer is empty.
// A two-entry result buffer keeps input accepting while one word waits.
// Reset (aresetn low, synchronous): sense, priority, pending, previous pins
// zero; mask all ones; result buffer empty. Depends on eip_pkg and submodules.
`timescale 1ns / 1ps

module external_irq_pin_controller_unit
    import eip_pkg::*;
#(
    parameter int PIN_COUNT        = PIN_COUNT_DEF,
    parameter int SENSE_FIELD_BITS = SENSE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_operation,
    input  logic [2:0]           s_reg_select,
    input  logic [WORD_BITS-1:0] s_write_data,
    input  logic [PIN_LIMIT-1:0] s_pin_levels,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [WORD_BITS-1:0] m_read_data,
    output logic [PIN_LIMIT-1:0] m_irq_lines,
    output logic                 m_shared_irq
);

    logic [WORD_BITS-1:0] sense_reg;
    logic [WORD_BITS-1:0] prio_reg;
    logic [PIN_LIMIT-1:0] pend_reg;
    logic [PIN_LIMIT-1:0] mask_reg;
    logic [PIN_COUNT-1:0] prev_reg;

    logic [WORD_BITS-1:0] prio_next;
    logic [PIN_LIMIT-1:0] mask_next;
    logic [PIN_LIMIT-1:0] pend_next;
    logic [PIN_COUNT-1:0] pins;
    logic [WORD_BITS-1:0] rd_data;
    logic                 accept;
    logic                 is_tick;
    logic                 is_wr;
    logic                 skid_valid;

    lane_ctrl_t  [PIN_COUNT-1:0] lane_ctrl;
    lane_out_t   [PIN_COUNT-1:0] lane_out;
    eip_result_t                 res_in;
    eip_result_t                 res_out;
    logic        [PIN_LIMIT-1:0] irq_lines;
    logic                        shared_irq;

    assign accept  = s_valid & s_ready;
    assign is_tick = s_operation == OP_TICK;
    assign is_wr   = s_operation == OP_WRITE;
    assign pins    = s_pin_levels[PIN_COUNT-1:0];

    // Next priority and mask after this item
    always_comb begin
        prio_next = prio_reg;
        mask_next = mask_reg;
        if (is_wr) begin
            unique case (s_reg_select)
                REG_PRIO:  prio_next = s_write_data;
                REG_MASK:  mask_next = mask_reg | s_write_data[PIN_LIMIT-1:0];
                REG_CLEAR: mask_next = mask_reg & ~s_write_data[PIN_LIMIT-1:0];
                default:   ;
            endcase
        end
    end

    // Register read mux
    always_comb begin
        rd_data = '0;
        if (s_operation == OP_READ) begin
            unique case (s_reg_select)
                REG_SENSE:  rd_data = sense_reg;
                REG_PRIO:   rd_data = prio_reg;
                REG_SOURCE: rd_data = WORD_BITS'(pend_reg);
                default:    rd_data = '0;
            endcase
        end
    end

    // Pin lanes
    for (genvar k = 0; k < PIN_COUNT; k++) begin : g_lane
        always_comb begin
            lane_ctrl[k].tick     = is_tick;
            lane_ctrl[k].src_wr   = is_wr && (s_reg_select == REG_SOURCE);
            lane_ctrl[k].src_keep = s_write_data[PIN_LIMIT-1-k];
            lane_ctrl[k].pend     = pend_reg[PIN_LIMIT-1-k];
            lane_ctrl[k].mask     = mask_next[PIN_LIMIT-1-k];
            lane_ctrl[k].prio_nz  =
                |prio_next[WORD_BITS-(k+1)*PRIO_BITS +: PRIO_BITS];
            lane_ctrl[k].prev     = prev_reg[k];
            lane_ctrl[k].cur      = pins[k];
        end

        eip_lane #(
            .SENSE_FIELD_BITS(SENSE_FIELD_BITS)
        ) u_lane (
            .sense_code(sense_reg[WORD_BITS-(k+1)*SENSE_FIELD_BITS +: SENSE_FIELD_BITS]),
            .ctrl      (lane_ctrl[k]),
            .result    (lane_out[k])
        );
    end

    // Combine lane findings
    eip_merge #(
        .PIN_COUNT(PIN_COUNT)
    ) u_merge (
        .lanes     (lane_out),
        .pend_next (pend_next),
        .irq_lines (irq_lines),
        .shared_irq(shared_irq)
    );

    // Controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sense_reg <= '0;
            prio_reg  <= '0;
            pend_reg  <= '0;
            mask_reg  <= '1;
            prev_reg  <= '0;
        end else if (accept) begin
            if (is_wr && s_reg_select == REG_SENSE) begin
                sense_reg <= s_write_data;
            end
            prio_reg <= prio_next;
            pend_reg <= pend_next;
            mask_reg <= mask_next;
            if (is_tick) begin
                prev_reg <= pins;
            end
        end
    end

    // Result word and output buffer
    always_comb begin
        res_in.read_data  = rd_data;
        res_in.irq_lines  = irq_lines;
        res_in.shared_irq = shared_irq;
    end

    eip_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (accept),
        .in_word   (res_in),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (res_out),
        .skid_valid(skid_valid)
    );

    assign m_read_data  = res_out.read_data;
    assign m_irq_lines  = res_out.irq_lines;
    assign m_shared_irq = res_out.shared_irq;

    // Skid entry only holds a word behind a waiting output word
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid |-> m_valid)
        else $error("skid word held without output word");

    // A sense write lands in the register
    a_sense_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_wr && s_reg_select == REG_SENSE) |=> sense_reg == $past(s_write_data))
        else $error("sense register not updated by write");

    // A tick records the sampled pin levels
    a_tick_prev: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_tick) |=> prev_reg == $past(pins))
        else $error("previous pins not captured on tick");

    // Shared line agrees with the per-pin lines of the presented word
    a_shared_or: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_shared_irq == (m_irq_lines != '0)))
        else $error("shared line disagrees with pin lines");

endmodule

// File: tb/external_irq_pin_controller_unit_test.sv
// Self-checking testbench for the eight-pin external interrupt controller.
// Depends on eip_pkg and external_irq_pin_controller_unit; the expected
// words come from a behavioral copy of the register and pin-sense logic.
`timescale 1ns / 1ps

module external_irq_pin_controller_unit_test;
    import eip_pkg::*;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          RANDOM_WORDS = 950;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          HOLD_AFTER   = 250;
    localparam logic [7:0]  PIN_MASK     = 8'((1 << PIN_COUNT_DEF) - 1);
    localparam logic [1:0]  OP_NONE      = 2'd3;
    localparam logic [2:0]  REG_SEL_5    = 3'd5;
    localparam logic [2:0]  REG_SEL_6    = 3'd6;
    localparam logic [2:0]  REG_SEL_7    = 3'd7;

    // One input word plus an optional hand-typed expectation
    typedef struct packed {
        logic [1:0]           op;
        logic [2:0]           sel;
        logic [WORD_BITS-1:0] data;
        logic [PIN_LIMIT-1:0] pins;
        bit                   typed;
        logic [WORD_BITS-1:0] exp_rd;
        logic [PIN_LIMIT-1:0] exp_lines;
    } irq_stim_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [1:0]           s_operation;
    logic [2:0]           s_reg_select;
    logic [WORD_BITS-1:0] s_write_data;
    logic [PIN_LIMIT-1:0] s_pin_levels;
    logic                 m_valid;
    logic                 m_ready;
    logic [WORD_BITS-1:0] m_read_data;
    logic [PIN_LIMIT-1:0] m_irq_lines;
    logic                 m_shared_irq;

    // Shadow copy of the controller state
    logic [WORD_BITS-1:0] sense_reg;
    logic [WORD_BITS-1:0] prio_reg;
    logic [7:0]           pend_reg;
    logic [7:0]           mask_reg;
    logic [7:0]           prev_pins;

    eip_result_t irq_result_q[$];

    int  cycle_count   = 0;
    int  error_count   = 0;
    int  words_checked = 0;
    int  irq_words     = 0;
    int  tick_count    = 0;
    int  read_count    = 0;
    int  write_count   = 0;
    int  other_count   = 0;
    bit  hold_active   = 1'b0;
    bit  hold_done     = 1'b0;
    bit  sender_burst  = 1'b0;

    // Directed words: reset contents, extremes, every sense code, odd selects
    irq_stim_t directed_tab [26] = '{
        '{OP_READ,  REG_SENSE,  32'h0,        8'h00, 1'b1, 32'h0,        8'h00},
        '{OP_READ,  REG_PRIO,   32'h0,        8'h00, 1'b1, 32'h0,        8'h00},
        '{OP_READ,  REG_SOURCE, 32'h0,        8'h00, 1'b1, 32'h0,        8'h00},
        '{OP_READ,  REG_MASK,   32'h0,        8'h00, 1'b1, 32'h0,        8'h00},
        '{OP_READ,  REG_CLEAR,  32'h0,        8'h00, 1'b1, 32'h0,        8'h00},
        '{OP_READ,  REG_SEL_7,  32'h0,        8'h00, 1'b1, 32'h0,        8'h00},
        '{OP_NONE,  REG_SEL_7,  32'hFFFFFFFF, 8'hFF, 1'b1, 32'h0,        8'h00},
        '{OP_TICK,  REG_SENSE,  32'h0,        8'hFF, 1'b0, 32'h0,        8'h00},
        '{OP_WRITE, REG_SENSE,  32'hFFFFFFFF, 8'h00, 1'b0, 32'h0,        8'h00},
        '{OP_READ,  REG_SENSE,  32'h0,        8'h00, 1'b1, 32'hFFFFFFFF, 8'h00},
        // pins 0..7: fall, rise, low, high, both, undefined, undefined, both
        '{OP_WRITE, REG_SENSE,  32'h01234F54, 8'h00, 1'b0, 32'h0,        8'h00},
        '{OP_WRITE, REG_PRIO,   32'hFFFFFFFF, 8'h00, 1'b0, 32'h0,        8'h00},
        '{OP_READ,  REG_PRIO,   32'h0,        8'h00, 1'b1, 32'hFFFFFFFF, 8'h00},
        '{OP_WRITE, REG_CLEAR,  32'h000000FF, 8'h00, 1'b0, 32'h0,        8'h00},
        '{OP_TICK,  REG_SENSE,  32'h0,        8'h00, 1'b0, 32'h0,        8'h00},
        '{OP_TICK,  REG_SENSE,  32'h0,        8'hFF, 1'b0, 32'h0,        8'h00},
        '{OP_READ,  REG_SOURCE, 32'h0,        8'h00, 1'b0, 32'h0,        8'h00},
        '{OP_WRITE, REG_SOURCE, 32'hFFFFFF00, 8'h00, 1'b0, 32'h0,        8'h00},
        '{OP_READ,  REG_SOURCE, 32'h0,        8'h00, 1'b0, 32'h0,        8'h00},
        '{OP_TICK,  REG_SENSE,  32'h0,        8'h0F, 1'b0, 32'h0,        8'h00},
        '{OP_WRITE, REG_MASK,   32'h000000AA, 8'h00, 1'b0, 32'h0,        8'h00},
        '{OP_WRITE, REG_SEL_5,  32'hFFFFFFFF, 8'h00, 1'b0, 32'h0,        8'h00},
        '{OP_WRITE, REG_SEL_7,  32'h00000000, 8'h00, 1'b0, 32'h0,        8'h00},
        '{OP_WRITE, REG_PRIO,   32'h00000000, 8'h00, 1'b0, 32'h0,        8'h00},
        '{OP_WRITE, REG_SOURCE, 32'h000000FF, 8'h00, 1'b0, 32'h0,        8'h00},
        '{OP_READ,  REG_SEL_6,  32'h0,        8'h00, 1'b0, 32'h0,        8'h00}
    };

    external_irq_pin_controller_unit #(
        .PIN_COUNT        (PIN_COUNT_DEF),
        .SENSE_FIELD_BITS (SENSE_BITS_DEF)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_reg_select (s_reg_select),
        .s_write_data (s_write_data),
        .s_pin_levels (s_pin_levels),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .m_irq_lines  (m_irq_lines),
        .m_shared_irq (m_shared_irq)
    );

    // 100 MHz clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Cycle counter and timeout
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL external_irq_pin_controller_unit");
        $finish;
    end

    // Applies one word to the shadow state, returns the word the block owes
    function automatic eip_result_t irq_ctrl_predict(input logic [1:0] op,
                                                     input logic [2:0] sel,
                                                     input logic [WORD_BITS-1:0] data,
                                                     input logic [PIN_LIMIT-1:0] pins_in);
        logic [7:0]                 pins;
        logic [7:0]                 lines;
        logic [SENSE_CODE_BITS-1:0] code;
        logic                       prev_b;
        logic                       cur_b;
        logic                       fire;
        eip_result_t                res;
        pins  = pins_in & PIN_MASK;
        lines = '0;
        res   = '0;
        case (op)
            OP_TICK: begin
                for (int k = 0; k < PIN_COUNT_DEF; k++) begin
                    code   = sense_reg[WORD_BITS - (k + 1) * SENSE_BITS_DEF +: SENSE_BITS_DEF];
                    prev_b = prev_pins[k];
                    cur_b  = pins[k];
                    case (code)
                        SENSE_FALL: fire = prev_b & ~cur_b;
                        SENSE_RISE: fire = ~prev_b & cur_b;
                        SENSE_LOW:  fire = ~cur_b;
                        SENSE_HIGH: fire = cur_b;
                        SENSE_BOTH: fire = prev_b ^ cur_b;
                        default:    fire = 1'b0;
                    endcase
                    if (fire) pend_reg[7 - k] = 1'b1;
                end
                prev_pins = pins;
            end
            OP_READ: begin
                case (sel)
                    REG_SENSE:  res.read_data = sense_reg;
                    REG_PRIO:   res.read_data = prio_reg;
                    REG_SOURCE: res.read_data = {24'b0, pend_reg};
                    default:    res.read_data = '0;
                endcase
            end
            OP_WRITE: begin
                case (sel)
                    REG_SENSE:  sense_reg = data;
                    REG_PRIO:   prio_reg  = data;
                    REG_SOURCE: pend_reg  = pend_reg & data[7:0];
                    REG_MASK:   mask_reg  = mask_reg | data[7:0];
                    REG_CLEAR:  mask_reg  = mask_reg & ~data[7:0];
                    default: ;
                endcase
            end
            default: ;
        endcase
        // pending, unmasked and a nonzero priority raise the pin's line
        for (int k = 0; k < PIN_COUNT_DEF; k++) begin
            if (pend_reg[7 - k] && !mask_reg[7 - k] &&
                prio_reg[WORD_BITS - (k + 1) * PRIO_BITS +: PRIO_BITS] != '0)
                lines[k] = 1'b1;
        end
        res.irq_lines  = lines & PIN_MASK;
        res.shared_irq = |res.irq_lines;
        return res;
    endfunction

    // Offers one word, waits for acceptance, records what it must produce
    task automatic send_word(input irq_stim_t row);
        int          gap;
        eip_result_t pred;
        gap = (hold_active || sender_burst) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= row.op;
        s_reg_select <= row.sel;
        s_write_data <= row.data;
        s_pin_levels <= row.pins;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = irq_ctrl_predict(row.op, row.sel, row.data, row.pins);
        if (row.typed) begin
            pred.read_data  = row.exp_rd;
            pred.irq_lines  = row.exp_lines;
            pred.shared_irq = |row.exp_lines;
        end
        irq_result_q.push_back(pred);
        case (row.op)
            OP_TICK:  tick_count++;
            OP_READ:  read_count++;
            OP_WRITE: write_count++;
            default:  other_count++;
        endcase
    endtask

    // Sense word: mostly defined codes, sometimes undefined ones
    function automatic logic [WORD_BITS-1:0] rand_sense_word();
        logic [WORD_BITS-1:0] w;
        w = '0;
        for (int k = 0; k < 8; k++) begin
            if ($urandom_range(0, 99) < 85)
                w[k * 4 +: 4] = 4'($urandom_range(0, 4));
            else
                w[k * 4 +: 4] = 4'($urandom_range(5, 15));
        end
        return w;
    endfunction

    // Priority word: mostly enabled pins, a few disabled fields
    function automatic logic [WORD_BITS-1:0] rand_prio_word();
        logic [WORD_BITS-1:0] w;
        w = '0;
        for (int k = 0; k < 8; k++) begin
            if ($urandom_range(0, 99) < 75)
                w[k * 4 +: 4] = 4'($urandom_range(1, 15));
        end
        return w;
    endfunction

    // Stimulus
    initial begin : stimulus
        irq_stim_t  row;
        logic [7:0] last_pins;
        int         pick;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_operation  <= OP_TICK;
        s_reg_select <= REG_SENSE;
        s_write_data <= '0;
        s_pin_levels <= '0;
        sense_reg    = '0;
        prio_reg     = '0;
        pend_reg     = '0;
        mask_reg     = 8'hFF;
        prev_pins    = '0;
        last_pins    = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_tab[i]) send_word(directed_tab[i]);

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            sender_burst = ((i / 90) % 4 == 3);
            row       = '0;
            row.data  = {$urandom};
            pick      = $urandom_range(0, 99);
            // pins: mostly one or two toggles from the last level, else random
            if ($urandom_range(0, 99) < 70) begin
                row.pins = last_pins ^ (8'h1 << $urandom_range(0, 7));
                if ($urandom_range(0, 1)) row.pins ^= (8'h1 << $urandom_range(0, 7));
            end else begin
                row.pins = 8'($urandom);
            end
            if (pick < 50) begin
                row.op    = OP_TICK;
                row.sel   = 3'($urandom_range(0, 7));
                last_pins = row.pins;
            end else if (pick < 65) begin
                row.op  = OP_READ;
                row.sel = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                      : 3'($urandom_range(0, 4));
            end else if (pick < 97) begin
                row.op = OP_WRITE;
                pick   = $urandom_range(0, 99);
                if (pick < 15) begin
                    row.sel  = REG_SENSE;
                    row.data = ($urandom_range(0, 19) == 0) ? {$urandom} : rand_sense_word();
                end else if (pick < 25) begin
                    row.sel  = REG_PRIO;
                    row.data = ($urandom_range(0, 19) == 0) ? {$urandom} : rand_prio_word();
                end else if (pick < 55) begin
                    row.sel = REG_SOURCE;
                end else if (pick < 75) begin
                    row.sel = REG_MASK;
                end else if (pick < 95) begin
                    row.sel = REG_CLEAR;
                end else begin
                    row.sel = 3'($urandom_range(5, 7));
                end
            end else begin
                row.op  = OP_NONE;
                row.sel = 3'($urandom_range(0, 7));
            end
            send_word(row);
        end
        s_valid <= 1'b0;

        while (irq_result_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Run covered %0d ticks, %0d reads, %0d writes, %0d no-op words.",
                 tick_count, read_count, write_count, other_count);
        $display("%0d result words checked, %0d with a request raised; one %0d-cycle output stall.",
                 words_checked, irq_words, HOLD_CYCLES);
        if (error_count == 0)
            $display("PASS external_irq_pin_controller_unit");
        else
            $display("FAIL external_irq_pin_controller_unit");
        $finish;
    end

    // Result side: random stalls, one long hold-off, field-by-field check
    initial begin : result_sink
        int          gap;
        eip_result_t want;
        m_ready <= 1'b0;
        wait (aresetn);
        forever begin
            if (!hold_done && words_checked >= HOLD_AFTER) begin
                hold_active = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_active = 1'b0;
                hold_done   = 1'b1;
            end else begin
                gap = ((words_checked / 100) % 3 == 2) ? 0 : $urandom_range(0, 19);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            if (irq_result_q.size() == 0) begin
                error_count++;
                $error("result word with nothing expected: read_data %h irq_lines %h",
                       m_read_data, m_irq_lines);
            end else begin
                want = irq_result_q.pop_front();
                words_checked++;
                if (m_irq_lines != 0) irq_words++;
                if (m_read_data !== want.read_data) begin
                    error_count++;
                    $error("read_data: expected %h, got %h", want.read_data, m_read_data);
                end
                if (m_irq_lines !== want.irq_lines) begin
                    error_count++;
                    $error("irq_lines: expected %h, got %h", want.irq_lines, m_irq_lines);
                end
                if (m_shared_irq !== want.shared_irq) begin
                    error_count++;
                    $error("shared_irq: expected %b, got %b", want.shared_irq, m_shared_irq);
                end
            end
        end
    end

endmodule
